@@ rtl/mexp_pkg.sv @@
package mexp_pkg;

  localparam int OperandWidthDefault = 31;
  localparam longint unsigned ModulusReset = 64'd2147483647;

  typedef struct packed {
    logic load;
    logic red_shift;
    logic mul_start;
    logic mul_dbl;
    logic mul_add;
    logic mul_end;
    logic out_load;
  } mexp_cmd_t;

  typedef struct packed {
    logic e_zero;
  } mexp_stat_t;

endpackage

@@ rtl/mexp_if.sv @@
interface mexp_req_if #(
  parameter int W = mexp_pkg::OperandWidthDefault
) ();
  logic         valid;
  logic         ready;
  logic         action;
  logic [W-1:0] base;
  logic [W-1:0] exponent;

  modport source(output valid, output action, output base, output exponent, input ready);
  modport sink(input valid, input action, input base, input exponent, output ready);
endinterface

interface mexp_rsp_if #(
  parameter int W = mexp_pkg::OperandWidthDefault
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] result;

  modport source(output valid, output result, input ready);
  modport sink(input valid, input result, output ready);
endinterface

@@ rtl/mexp_dp.sv @@
module mexp_dp #(
  parameter int W  = mexp_pkg::OperandWidthDefault,
  parameter int IW = $clog2(W)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [W-1:0]           cfg_wdata,
  input  mexp_pkg::mexp_cmd_t    cmd,
  input  logic [IW-1:0]          idx,
  input  logic                   action,
  input  logic [W-1:0]           base,
  input  logic [W-1:0]           exponent,
  output mexp_pkg::mexp_stat_t   stat,
  output logic [W-1:0]           result
);
  import mexp_pkg::*;

  logic [W-1:0] modulus;
  logic [W-1:0] m;
  logic [W-1:0] b_in;
  logic [W-1:0] e;
  logic [W-1:0] sq;
  logic [W-1:0] acc;
  logic [W-1:0] ra;
  logic [W-1:0] rs;

  logic [W-1:0] m_eff;
  logic [W-1:0] inv_e;
  logic [W-1:0] one_red;
  logic [W-1:0] add_a;
  logic [W-1:0] add_s;

  // x < 2m on entry
  function automatic logic [W-1:0] red(input logic [W:0] x, input logic [W-1:0] md);
    logic [W:0] d;
    d = x - {1'b0, md};
    return (x >= {1'b0, md}) ? d[W-1:0] : x[W-1:0];
  endfunction

  assign m_eff   = (modulus == '0) ? W'(1) : modulus;
  assign inv_e   = (m_eff >= W'(2)) ? m_eff - W'(2) : '0;
  assign one_red = (m_eff == W'(1)) ? '0 : W'(1);
  assign add_a   = sq[idx] ? acc : '0;
  assign add_s   = sq[idx] ? sq : '0;

  assign stat.e_zero = (e == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(ModulusReset);
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m    <= m_eff;
      b_in <= base;
      e    <= action ? inv_e : exponent;
      acc  <= one_red;
      sq   <= '0;
    end
    if (cmd.red_shift) begin
      sq <= red({sq, b_in[idx]}, m);
    end
    if (cmd.mul_start) begin
      ra <= '0;
      rs <= '0;
    end
    if (cmd.mul_dbl) begin
      ra <= red({ra, 1'b0}, m);
      rs <= red({rs, 1'b0}, m);
    end
    if (cmd.mul_add) begin
      ra <= red({1'b0, ra} + {1'b0, add_a}, m);
      rs <= red({1'b0, rs} + {1'b0, add_s}, m);
    end
    if (cmd.mul_end) begin
      if (e[0]) begin
        acc <= ra;
      end
      sq <= rs;
      e  <= e >> 1;
    end
    if (cmd.out_load) begin
      result <= acc;
    end
  end

endmodule

@@ rtl/mexp_ctrl.sv @@
module mexp_ctrl #(
  parameter int W  = mexp_pkg::OperandWidthDefault,
  parameter int IW = $clog2(W)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  input  mexp_pkg::mexp_stat_t   stat,
  output mexp_pkg::mexp_cmd_t    cmd,
  output logic [IW-1:0]          idx
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_CHECK,
    S_DBL,
    S_ADD,
    S_COMMIT,
    S_FINISH
  } state_t;

  localparam logic [IW-1:0] LastIdx = IW'(W - 1);

  state_t        state;
  logic [IW-1:0] cnt;

  assign idx       = cnt;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:   cmd.load      = req_valid;
      S_REDUCE: cmd.red_shift = 1'b1;
      S_CHECK:  cmd.mul_start = !stat.e_zero;
      S_DBL:    cmd.mul_dbl   = 1'b1;
      S_ADD:    cmd.mul_add   = 1'b1;
      S_COMMIT: cmd.mul_end   = 1'b1;
      S_FINISH: cmd.out_load  = !rsp_valid || rsp_ready;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == S_FINISH) && cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_REDUCE;
            cnt   <= LastIdx;
          end
        end
        S_REDUCE: begin
          if (cnt == '0) begin
            state <= S_CHECK;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_CHECK: begin
          if (stat.e_zero) begin
            state <= S_FINISH;
          end else begin
            state <= S_DBL;
            cnt   <= LastIdx;
          end
        end
        S_DBL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          if (cnt == '0) begin
            state <= S_COMMIT;
          end else begin
            cnt   <= cnt - 1'b1;
            state <= S_DBL;
          end
        end
        S_COMMIT: begin
          state <= S_CHECK;
        end
        S_FINISH: begin
          if (cmd.out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/modular_exponentiation.sv @@
// Modular exponentiation, right-to-left square-and-multiply.
// req (valid/ready): action, base, exponent. action 0 gives base^exponent,
// action 1 gives base^(modulus-2), the inverse for a prime modulus.
// rsp (valid/ready): result, one per request, in order.
// cfg_we/cfg_wdata write the modulus (zero acts as one); write only when idle.
// Steps, with W = OPERAND_WIDTH and k = position of the highest set exponent
// bit plus one (0 for a zero exponent): accept, base reduction over W base
// bits, then k rounds of check, modular products and commit, a last check
// and the finish. Each modular product is a shift-and-add over W multiplier
// bits; the square and the accumulator product run side by side in the
// datapath.
// One request is in work at a time: req.ready is high only when idle.
// The result sits in an output register; a new request is taken while it
// waits, and a finished result holds until rsp.ready frees the register.
// Reset (rst, synchronous) empties the block and sets modulus to 2^31-1.
module modular_exponentiation #(
  parameter int OPERAND_WIDTH = mexp_pkg::OperandWidthDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [OPERAND_WIDTH-1:0] cfg_wdata,
  mexp_req_if.sink                 req,
  mexp_rsp_if.source               rsp
);
  import mexp_pkg::*;

  localparam int IW = $clog2(OPERAND_WIDTH);

  mexp_cmd_t     cmd;
  mexp_stat_t    stat;
  logic [IW-1:0] idx;

  mexp_ctrl #(
    .W  (OPERAND_WIDTH),
    .IW (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd),
    .idx       (idx)
  );

  mexp_dp #(
    .W  (OPERAND_WIDTH),
    .IW (IW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .idx       (idx),
    .action    (req.action),
    .base      (req.base),
    .exponent  (req.exponent),
    .stat      (stat),
    .result    (rsp.result)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp.valid || rsp.ready))
    else $error("pending result overwritten");

  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (req.valid && req.ready))
    else $error("operands loaded without a request");

endmodule

@@ verif/tb_modular_exponentiation.sv @@
`timescale 1ns / 100ps

module tb_modular_exponentiation;

  localparam int W = mexp_pkg::OperandWidthDefault;
  localparam logic [W-1:0] MOD_MAX = {W{1'b1}};
  localparam logic [W-1:0] MOD_MAX_M1 = MOD_MAX - 1'b1;
  localparam int ITEMS_PER_PHASE = 45;
  localparam int NUM_PHASES = 6;
  localparam int END_WAIT = 2100;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef enum logic {
    OP_POW = 1'b0,
    OP_INV = 1'b1
  } op_e;

  typedef struct packed {
    logic [W-1:0] modulus;
    op_e          op;
    logic [W-1:0] base;
    logic [W-1:0] exponent;
    logic         known;
    logic [W-1:0] result;
  } vector_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         cfg_we;
  logic [W-1:0] cfg_wdata;

  mexp_req_if #(.W(W)) req_if ();
  mexp_rsp_if #(.W(W)) rsp_if ();

  modular_exponentiation #(.OPERAND_WIDTH(W)) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .req(req_if),
    .rsp(rsp_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  vector_t directed_vectors [0:21] = '{
    '{MOD_MAX, OP_POW, 0, 0, 1, 1},
    '{MOD_MAX, OP_POW, MOD_MAX, 1, 1, 0},
    '{MOD_MAX, OP_POW, MOD_MAX_M1, 1, 1, MOD_MAX_M1},
    '{MOD_MAX, OP_POW, 2, 30, 1, 31'h4000_0000},
    '{MOD_MAX, OP_POW, MOD_MAX_M1, MOD_MAX, 1, MOD_MAX_M1},
    '{MOD_MAX, OP_POW, 3, MOD_MAX_M1, 1, 1},
    '{MOD_MAX, OP_POW, 31'h2A5A_5A5A, 31'h55A5_A5A5, 0, 0},
    '{MOD_MAX, OP_POW, MOD_MAX, 0, 1, 1},
    '{MOD_MAX, OP_INV, 1, 0, 1, 1},
    '{MOD_MAX, OP_INV, MOD_MAX_M1, MOD_MAX, 1, MOD_MAX_M1},
    '{MOD_MAX, OP_INV, 31'h1234_5678, 31'h0765_4321, 0, 0},
    '{MOD_MAX, OP_INV, MOD_MAX, 0, 1, 0},
    '{1, OP_POW, 5, 0, 1, 0},
    '{1, OP_INV, MOD_MAX, MOD_MAX, 1, 0},
    '{0, OP_POW, MOD_MAX, MOD_MAX, 1, 0},
    '{0, OP_INV, 3, 0, 1, 0},
    '{2, OP_INV, 4, 0, 1, 1},
    '{2, OP_POW, 3, 5, 1, 1},
    '{15, OP_INV, 2, 0, 0, 0},
    '{15, OP_POW, 0, 0, 1, 1},
    '{15, OP_INV, 30, 0, 1, 0},
    '{3, OP_INV, 2, 0, 1, 2}
  };

  logic [W-1:0] modulus_cfg = W'(mexp_pkg::ModulusReset);
  logic [W-1:0] pending_results [$];
  logic [W-1:0] oldest_result;
  int req_idle_pct;
  int rsp_idle_pct;
  int n_err;
  int n_req;
  int n_inv;
  int n_checked;
  int n_mod_writes;
  int cycle_count = 0;

  // base^exponent mod modulus, or base^(modulus-2) for the inverse; modulus 0 acts as 1
  function automatic logic [W-1:0] power_mod(input op_e op, input logic [W-1:0] b,
                                             input logic [W-1:0] e, input logic [W-1:0] mcfg);
    longint unsigned m;
    longint unsigned pw;
    longint unsigned acc;
    longint unsigned sq;
    m = (mcfg == '0) ? 64'd1 : 64'(mcfg);
    if (op == OP_INV) begin
      pw = (m >= 64'd2) ? m - 64'd2 : 64'd0;
    end else begin
      pw = 64'(e);
    end
    acc = 64'd1 % m;
    sq = 64'(b) % m;
    for (int i = 0; i < W; i++) begin
      if (pw[i]) begin
        acc = (acc * sq) % m;
      end
      sq = (sq * sq) % m;
    end
    return acc[W-1:0];
  endfunction

  task automatic set_idle(input int send_pct, input int recv_pct);
    req_idle_pct = send_pct;
    rsp_idle_pct = recv_pct;
  endtask

  task automatic issue_request(input op_e op, input logic [W-1:0] b, input logic [W-1:0] e,
                               input logic known, input logic [W-1:0] typed);
    logic [W-1:0] want;
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.action <= op;
    req_if.base <= b;
    req_if.exponent <= e;
    do @(posedge clk); while (!req_if.ready);
    want = known ? typed : power_mod(op, b, e, modulus_cfg);
    pending_results.push_back(want);
    n_req++;
    if (op == OP_INV) begin
      n_inv++;
    end
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    modulus_cfg = value;
    n_mod_writes++;
  endtask

  task automatic random_request();
    op_e          op;
    logic [W-1:0] b;
    logic [31:0]  e_bits;
    int           len;
    op = ($urandom_range(0, 3) == 0) ? OP_INV : OP_POW;
    case ($urandom_range(0, 7))
      0: b = '0;
      1: b = MOD_MAX;
      2: b = modulus_cfg;
      3: b = W'($urandom_range(0, 15));
      default: b = W'($urandom);
    endcase
    len = $urandom_range(0, W);
    if (len == 0) begin
      e_bits = '0;
    end else begin
      e_bits = ($urandom & ((32'd1 << len) - 32'd1)) | (32'd1 << (len - 1));
    end
    issue_request(op, b, e_bits[W-1:0], 1'b0, '0);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result %h with no request outstanding", $time, rsp_if.result);
        n_err++;
      end else begin
        oldest_result = pending_results.pop_front();
        n_checked++;
        if (rsp_if.result !== oldest_result) begin
          $display("%0t: result mismatch, expected %h, got %h", $time, oldest_result,
                   rsp_if.result);
          n_err++;
        end
      end
    end
    rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_if.valid <= 1'b0;
    req_if.action <= OP_POW;
    req_if.base <= '0;
    req_if.exponent <= '0;
    n_err = 0;
    n_req = 0;
    n_inv = 0;
    n_checked = 0;
    n_mod_writes = 0;
    set_idle(22, 71);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_vectors[i]) begin
      if (directed_vectors[i].modulus != modulus_cfg) begin
        drain_results();
        write_modulus(directed_vectors[i].modulus);
      end
      issue_request(directed_vectors[i].op, directed_vectors[i].base,
                    directed_vectors[i].exponent, directed_vectors[i].known,
                    directed_vectors[i].result);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      case (phase / 2)
        0: set_idle(22, 71);
        1: set_idle(71, 22);
        default: set_idle(0, 0);
      endcase
      case (phase)
        0: write_modulus(MOD_MAX);
        1: write_modulus(W'($urandom) | (W'(1) << (W - 1)));
        2: write_modulus(W'(65521));
        3: write_modulus(W'($urandom_range(2, 255)));
        4: write_modulus(W'(1) << (W - 1));
        default: write_modulus(W'($urandom));
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) begin
          drain_results();
        end
        random_request();
      end
    end

    drain_results();
    repeat (END_WAIT) @(posedge clk);
    $display("Sent %0d requests (%0d inverse) under %0d modulus writes, checked %0d results",
             n_req, n_inv, n_mod_writes, n_checked);
    $display("Run took %0d cycles with mixed sender/receiver stalls", cycle_count);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ modular_exponentiation.f @@
rtl/mexp_pkg.sv
rtl/mexp_if.sv
rtl/mexp_dp.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation.sv
verif/tb_modular_exponentiation.sv
